@@ hw/rtl/zssc_pkg.sv @@
// Shared types, codes and helpers for the zlib stored-size scanner.
`default_nettype none

package zssc_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_COMP  = 3'd1,
        ST_HDR   = 3'd2,
        ST_BAD   = 3'd3,
        ST_TRUNC = 3'd4
    } status_t;

    // Scan phases, one-hot
    typedef enum logic [10:0] {
        PH_CMF   = 11'b000_0000_0001,
        PH_FLG   = 11'b000_0000_0010,
        PH_FIRST = 11'b000_0000_0100,
        PH_HDR   = 11'b000_0000_1000,
        PH_LEN0  = 11'b000_0001_0000,
        PH_LEN1  = 11'b000_0010_0000,
        PH_NLEN0 = 11'b000_0100_0000,
        PH_NLEN1 = 11'b000_1000_0000,
        PH_SKIP  = 11'b001_0000_0000,
        PH_CWAIT = 11'b010_0000_0000,
        PH_DONE  = 11'b100_0000_0000
    } phase_t;

    // Deflate block type codes
    localparam logic [1:0] BTYPE_STORED   = 2'd0;
    localparam logic [1:0] BTYPE_RESERVED = 2'd3;

    localparam logic [15:0] LEN_COMPLEMENT = 16'hFFFF;
    localparam logic [31:0] SIZE_COMPRESSED = 32'hFFFF_FFFF;
    // Bytes that follow a leading compressed block header before its result
    localparam logic [15:0] COMP_WAIT_BYTES = 16'd3;

    // True when the 16-bit header word is a multiple of 31.
    // Since 32 is 1 mod 31, summing 5-bit digits keeps the residue.
    function automatic logic hdr_check_ok(input logic [15:0] word);
        logic [6:0] sum1;
        logic [5:0] sum2;
        sum1 = {2'b00, word[4:0]} + {2'b00, word[9:5]} + {2'b00, word[14:10]}
             + {6'b0, word[15]};
        sum2 = {1'b0, sum1[4:0]} + {4'b0, sum1[6:5]};
        return (sum2 == 6'd0) || (sum2 == 6'd31);
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/zlib_stored_size_scanner_core.sv @@
// Top level of the zlib stored-size scanner: byte parser and result staging.
//
// Usage:
//   Bytes of a zlib stream enter on the slave stream, one per request, with
//   s_tlast marking the last byte of the stream. Each stream yields exactly
//   one result on the master stream: m_tdata carries the stored total (or
//   all ones for a compressed block, zero on error), m_tuser the status.
//   Throughput is one byte per cycle while s_tready is high: each byte is
//   parsed by the phase logic in the cycle it is taken, and its result, if
//   any, is registered in the output register, or in the one-entry skid
//   register behind it while an earlier result waits, so bytes keep flowing.
//   s_tready drops only while the skid register is full, that is once both
//   are full and the receiver has stalled; bytes after a stream's result
//   are consumed and dropped until s_tlast returns the parser to the start.
//   Reset (rst_n low, asynchronous) empties both result registers and puts
//   the parser at the first header byte with a zero total.
`default_nettype none

module zlib_stored_size_scanner_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    // Input stream
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,   // [7:0] data_byte
    input  wire logic             s_tlast,   // end_of_data
    // Result stream
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [31:0]           m_tdata,   // [31:0] size_value
    output zssc_pkg::status_t     m_tuser    // [2:0] status
);
    import zssc_pkg::*;

    // Parser state
    phase_t      phase_reg, phase_next;
    logic [7:0]  first_byte_reg, first_byte_next;
    logic        final_flag_reg, final_flag_next;
    logic [15:0] length_word_reg, length_word_next;
    logic [7:0]  inv_low_reg, inv_low_next;
    logic [15:0] skip_reg, skip_next;
    logic [31:0] total_reg, total_next;

    // Result of the current byte
    logic        res_valid;
    logic [31:0] res_size;
    status_t     res_status;

    // Output staging
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_size_reg, out_size_next;
    status_t     out_stat_reg, out_stat_next;
    logic        skid_valid_reg, skid_valid_next;
    logic [31:0] skid_size_reg, skid_size_next;
    status_t     skid_stat_reg, skid_stat_next;

    logic        in_accept;
    logic        out_pop;
    logic [15:0] skip_dec;
    logic [31:0] total_sum;
    logic [15:0] inv_word;
    logic [1:0]  kind;

    assign s_tready  = !skid_valid_reg;
    assign in_accept = s_tvalid && s_tready;
    assign out_pop   = out_valid_reg && m_tready;

    assign skip_dec  = skip_reg - 16'd1;
    assign total_sum = total_reg + {16'b0, length_word_reg};
    assign inv_word  = {s_tdata, inv_low_reg};
    assign kind      = s_tdata[2:1];

    // Parse one byte
    always_comb
    begin
        phase_next       = phase_reg;
        first_byte_next  = first_byte_reg;
        final_flag_next  = final_flag_reg;
        length_word_next = length_word_reg;
        inv_low_next     = inv_low_reg;
        skip_next        = skip_reg;
        total_next       = total_reg;
        res_valid        = 1'b0;
        res_size         = '0;
        res_status       = ST_OK;

        if (in_accept)
        begin
            case (phase_reg)
                PH_CMF:
                begin
                    first_byte_next = s_tdata;
                    if (s_tlast)
                    begin
                        res_valid  = 1'b1;
                        res_status = ST_TRUNC;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_FLG;
                    end
                end
                PH_FLG:
                begin
                    if (s_tlast)
                    begin
                        res_valid  = 1'b1;
                        res_status = ST_TRUNC;
                        phase_next = PH_DONE;
                    end
                    else if (!hdr_check_ok({first_byte_reg, s_tdata}))
                    begin
                        res_valid  = 1'b1;
                        res_status = ST_HDR;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_FIRST;
                    end
                end
                PH_FIRST, PH_HDR:
                begin
                    if (s_tlast)
                    begin
                        res_valid  = 1'b1;
                        res_status = ST_TRUNC;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        final_flag_next = s_tdata[0];
                        if (kind == BTYPE_STORED)
                        begin
                            phase_next = PH_LEN0;
                        end
                        else if (kind == BTYPE_RESERVED)
                        begin
                            res_valid  = 1'b1;
                            res_status = ST_BAD;
                            phase_next = PH_DONE;
                        end
                        else if (phase_reg == PH_FIRST)
                        begin
                            // Hold the compressed verdict until the stream is long enough
                            skip_next  = COMP_WAIT_BYTES;
                            phase_next = PH_CWAIT;
                        end
                        else
                        begin
                            res_valid  = 1'b1;
                            res_size   = SIZE_COMPRESSED;
                            res_status = ST_COMP;
                            phase_next = PH_DONE;
                        end
                    end
                end
                PH_LEN0, PH_LEN1, PH_NLEN0:
                begin
                    if (phase_reg == PH_LEN0)
                    begin
                        length_word_next = {8'b0, s_tdata};
                    end
                    else if (phase_reg == PH_LEN1)
                    begin
                        length_word_next = {s_tdata, length_word_reg[7:0]};
                    end
                    else
                    begin
                        inv_low_next = s_tdata;
                    end
                    if (s_tlast)
                    begin
                        res_valid  = 1'b1;
                        res_status = ST_TRUNC;
                        phase_next = PH_DONE;
                    end
                    else if (phase_reg == PH_LEN0)
                    begin
                        phase_next = PH_LEN1;
                    end
                    else if (phase_reg == PH_LEN1)
                    begin
                        phase_next = PH_NLEN0;
                    end
                    else
                    begin
                        phase_next = PH_NLEN1;
                    end
                end
                PH_NLEN1:
                begin
                    if ((length_word_reg ^ inv_word) != LEN_COMPLEMENT)
                    begin
                        res_valid  = 1'b1;
                        res_status = ST_BAD;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        total_next = total_sum;
                        if (final_flag_reg || s_tlast)
                        begin
                            res_valid  = 1'b1;
                            res_size   = total_sum;
                            res_status = ST_OK;
                            phase_next = PH_DONE;
                        end
                        else if (length_word_reg == 16'd0)
                        begin
                            phase_next = PH_HDR;
                        end
                        else
                        begin
                            skip_next  = length_word_reg;
                            phase_next = PH_SKIP;
                        end
                    end
                end
                PH_SKIP:
                begin
                    skip_next = skip_dec;
                    if (s_tlast)
                    begin
                        res_valid  = 1'b1;
                        res_size   = total_reg;
                        res_status = ST_OK;
                        phase_next = PH_DONE;
                    end
                    else if (skip_dec == 16'd0)
                    begin
                        phase_next = PH_HDR;
                    end
                end
                PH_CWAIT:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 16'd0)
                    begin
                        res_valid  = 1'b1;
                        res_size   = SIZE_COMPRESSED;
                        res_status = ST_COMP;
                        phase_next = PH_DONE;
                    end
                    else if (s_tlast)
                    begin
                        res_valid  = 1'b1;
                        res_status = ST_TRUNC;
                        phase_next = PH_DONE;
                    end
                end
                default:
                begin
                    // Done and unused codes: drop the byte
                end
            endcase

            // Return to the start of a stream after its last byte
            if (s_tlast)
            begin
                phase_next       = PH_CMF;
                first_byte_next  = '0;
                final_flag_next  = 1'b0;
                length_word_next = '0;
                inv_low_next     = '0;
                skip_next        = '0;
                total_next       = '0;
            end
        end
    end

    // Advance result staging
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_size_next   = out_size_reg;
        out_stat_next   = out_stat_reg;
        skid_valid_next = skid_valid_reg;
        skid_size_next  = skid_size_reg;
        skid_stat_next  = skid_stat_reg;

        if (skid_valid_reg)
        begin
            // No input is taken while the skid entry is full
            if (out_pop)
            begin
                out_valid_next  = 1'b1;
                out_size_next   = skid_size_reg;
                out_stat_next   = skid_stat_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || out_pop)
        begin
            out_valid_next = in_accept && res_valid;
            out_size_next  = res_size;
            out_stat_next  = res_status;
        end
        else if (in_accept && res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_size_next  = res_size;
            skid_stat_next  = res_status;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_CMF;
            total_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            total_reg      <= total_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        first_byte_reg  <= first_byte_next;
        final_flag_reg  <= final_flag_next;
        length_word_reg <= length_word_next;
        inv_low_reg     <= inv_low_next;
        skip_reg        <= skip_next;
        out_size_reg    <= out_size_next;
        out_stat_reg    <= out_stat_next;
        skid_size_reg   <= skid_size_next;
        skid_stat_reg   <= skid_stat_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_size_reg;
    assign m_tuser  = out_stat_reg;

endmodule

`default_nettype wire
